// ===== sv/layer_normalization_unit_assert.svh =====
// ----------------------------------------------------------------------------
// layer normalization unit assertion macros
// shared concurrent assertion forms, clocked on clk and held off in reset
// ----------------------------------------------------------------------------
`ifndef LAYER_NORMALIZATION_UNIT_ASSERT_SVH
`define LAYER_NORMALIZATION_UNIT_ASSERT_SVH

// same-cycle implication
`define LNU_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LNU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/lnu_pkg.sv =====
// ----------------------------------------------------------------------------
// lnu_pkg
// types and constants shared by the layer normalization unit
// ----------------------------------------------------------------------------
package lnu_pkg;

    localparam logic CMD_STATS = 1'b0;
    localparam logic CMD_NORM  = 1'b1;

    localparam logic REG_ROW_LEN = 1'b0;
    localparam logic REG_EPSILON = 1'b1;

    localparam int ROW_LEN_W = 13;
    localparam int EPS_W     = 16;
    localparam int CFG_W     = 16;
    localparam int INV_W     = 24;

    typedef struct packed {
        logic               command;
        logic signed [15:0] x_value;
        logic signed [15:0] gamma;
        logic signed [15:0] beta;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] y_value;
        logic               saturated;
    } out_item_t;

    // statistics of the last finished row
    typedef struct packed {
        logic signed [15:0] mean;
        logic [INV_W-1:0]   inv_std;
    } row_stat_t;

endpackage

// ===== sv/lnu_front.sv =====
// ----------------------------------------------------------------------------
// lnu_front
// request intake and short queue ahead of the execution side
// ----------------------------------------------------------------------------
module lnu_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  lnu_pkg::in_item_t in_data,
    output logic              q_valid,
    output lnu_pkg::in_item_t q_item,
    input  logic              q_pop
);
    import lnu_pkg::*;

    localparam int DEPTH = 4;
    localparam int AW    = $clog2(DEPTH);

    in_item_t        mem [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [AW:0]     count_reg, count_next;
    logic            push;

    assign in_stall = (count_reg == (AW+1)'(DEPTH));
    assign push     = in_valid && !in_stall;
    assign q_valid  = (count_reg != '0);
    assign q_item   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push  ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = q_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (AW+1)'(push) - (AW+1)'(q_pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== sv/lnu_stats.sv =====
// ----------------------------------------------------------------------------
// lnu_stats
// back-end issue control, row accumulation and end-of-row divide and root
// ----------------------------------------------------------------------------
`include "layer_normalization_unit_assert.svh"

module lnu_stats #(
    parameter int MAX_ROW_LEN = 4096
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           q_valid,
    input  lnu_pkg::in_item_t              q_item,
    output logic                           q_pop,
    input  logic                           norm_ready,
    output logic                           norm_issue,
    input  logic [lnu_pkg::ROW_LEN_W-1:0]  row_len,
    input  logic [lnu_pkg::EPS_W-1:0]      epsilon,
    output lnu_pkg::row_stat_t             row_stat
);
    import lnu_pkg::*;

    localparam int NW        = $clog2(MAX_ROW_LEN + 1);
    localparam int CW        = (NW > ROW_LEN_W) ? NW : ROW_LEN_W;
    localparam int DIV_STEPS = 49;
    localparam int SQ_STEPS  = 25;
    localparam logic [INV_W-1:0] INV_MAX = '1;

    typedef enum logic [2:0] {
        S_IDLE, S_DIV_SUM, S_DIV_SQ, S_MSQ, S_VAR, S_DIV_RCP, S_SQRT, S_DONE
    } state_t;

    state_t                state_reg;
    logic [28:0]           sum_acc_reg;
    logic [42:0]           sum_sq_acc_reg;
    logic [ROW_LEN_W-1:0]  stats_count_reg;
    row_stat_t             row_stat_reg;

    logic                  sum_neg_reg;
    logic signed [28:0]    mean_full_reg;
    logic [42:0]           esq_reg;
    logic [56:0]           msq_reg;
    logic [43:0]           div_rem_reg;
    logic [48:0]           div_quo_reg;
    logic [43:0]           div_den_reg;
    logic [49:0]           sq_src_reg;
    logic [25:0]           sq_rem_reg;
    logic [24:0]           sq_root_reg;
    logic [INV_W-1:0]      inv_work_reg;
    logic [5:0]            step_reg;

    // row length clamp
    logic [CW-1:0]         rl_ext, n_full;
    logic [ROW_LEN_W-1:0]  n_eff;

    // accumulate path
    logic signed [31:0]    x_sq;
    logic [28:0]           sum_next;
    logic [42:0]           sum_sq_next;
    logic [ROW_LEN_W-1:0]  count_next;
    logic                  stats_pop, row_end;

    // divider step
    logic [44:0]           rem_sh, rem_diff;
    logic                  div_ge;
    logic [43:0]           rem_new;
    logic [48:0]           quo_new;

    // root step
    logic [27:0]           sq_sh, sq_trial;
    logic                  sq_ge;
    logic [25:0]           sq_rem_new;
    logic [24:0]           sq_root_new;

    // variance
    logic [56:0]           esq_ext;
    logic [42:0]           var_val;
    logic [43:0]           d_val;
    logic [28:0]           sum_mag;

    assign row_stat = row_stat_reg;

    always_comb
    begin
        rl_ext = CW'(row_len);
        if (rl_ext == '0)
        begin
            n_full = CW'(1);
        end
        else if (rl_ext > CW'(MAX_ROW_LEN))
        begin
            n_full = CW'(MAX_ROW_LEN);
        end
        else
        begin
            n_full = rl_ext;
        end
        n_eff = n_full[ROW_LEN_W-1:0];
    end

    always_comb
    begin
        q_pop      = 1'b0;
        norm_issue = 1'b0;
        if (q_valid && state_reg == S_IDLE)
        begin
            if (q_item.command == CMD_STATS)
            begin
                q_pop = 1'b1;
            end
            else if (norm_ready)
            begin
                q_pop      = 1'b1;
                norm_issue = 1'b1;
            end
        end
        stats_pop   = q_pop && !norm_issue;
        x_sq        = q_item.x_value * q_item.x_value;
        sum_next    = sum_acc_reg + {{13{q_item.x_value[15]}}, q_item.x_value};
        sum_sq_next = sum_sq_acc_reg + 43'(unsigned'(x_sq));
        count_next  = stats_count_reg + 1'b1;
        row_end     = stats_pop && (count_next >= n_eff);
        sum_mag     = sum_next[28] ? (~sum_next + 1'b1) : sum_next;
    end

    always_comb
    begin
        rem_sh   = {div_rem_reg, div_quo_reg[48]};
        rem_diff = rem_sh - {1'b0, div_den_reg};
        div_ge   = (rem_sh >= {1'b0, div_den_reg});
        rem_new  = div_ge ? rem_diff[43:0] : rem_sh[43:0];
        quo_new  = {div_quo_reg[47:0], div_ge};

        sq_sh       = {sq_rem_reg, sq_src_reg[49:48]};
        sq_trial    = {1'b0, sq_root_reg, 2'b01};
        sq_ge       = (sq_sh >= sq_trial);
        sq_rem_new  = sq_ge ? 26'(sq_sh - sq_trial) : sq_sh[25:0];
        sq_root_new = {sq_root_reg[23:0], sq_ge};

        esq_ext = 57'(esq_reg);
        var_val = (esq_ext > msq_reg) ? 43'(esq_ext - msq_reg) : '0;
        d_val   = 44'(var_val) + 44'(epsilon);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            sum_acc_reg     <= '0;
            sum_sq_acc_reg  <= '0;
            stats_count_reg <= '0;
            row_stat_reg    <= '0;
            step_reg        <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (stats_pop)
                    begin
                        sum_acc_reg     <= sum_next;
                        sum_sq_acc_reg  <= sum_sq_next;
                        stats_count_reg <= count_next;
                    end
                    if (row_end)
                    begin
                        sum_neg_reg <= sum_next[28];
                        div_quo_reg <= 49'(sum_mag);
                        div_rem_reg <= '0;
                        div_den_reg <= 44'(n_eff);
                        step_reg    <= '0;
                        state_reg   <= S_DIV_SUM;
                    end
                end
                S_DIV_SUM:
                begin
                    div_rem_reg <= rem_new;
                    div_quo_reg <= quo_new;
                    step_reg    <= step_reg + 1'b1;
                    if (step_reg == 6'(DIV_STEPS - 1))
                    begin
                        mean_full_reg <= sum_neg_reg ? -$signed(quo_new[28:0])
                                                     : $signed(quo_new[28:0]);
                        div_quo_reg   <= 49'(sum_sq_acc_reg);
                        div_rem_reg   <= '0;
                        step_reg      <= '0;
                        state_reg     <= S_DIV_SQ;
                    end
                end
                S_DIV_SQ:
                begin
                    div_rem_reg <= rem_new;
                    div_quo_reg <= quo_new;
                    step_reg    <= step_reg + 1'b1;
                    if (step_reg == 6'(DIV_STEPS - 1))
                    begin
                        esq_reg   <= quo_new[42:0];
                        step_reg  <= '0;
                        state_reg <= S_MSQ;
                    end
                end
                S_MSQ:
                begin
                    msq_reg   <= 57'(unsigned'(58'(mean_full_reg * mean_full_reg)));
                    state_reg <= S_VAR;
                end
                S_VAR:
                begin
                    if (d_val == '0)
                    begin
                        inv_work_reg <= INV_MAX;
                        state_reg    <= S_DONE;
                    end
                    else
                    begin
                        div_den_reg <= d_val;
                        div_quo_reg <= {1'b1, 48'd0};
                        div_rem_reg <= '0;
                        step_reg    <= '0;
                        state_reg   <= S_DIV_RCP;
                    end
                end
                S_DIV_RCP:
                begin
                    div_rem_reg <= rem_new;
                    div_quo_reg <= quo_new;
                    step_reg    <= step_reg + 1'b1;
                    if (step_reg == 6'(DIV_STEPS - 1))
                    begin
                        sq_src_reg  <= {1'b0, quo_new};
                        sq_rem_reg  <= '0;
                        sq_root_reg <= '0;
                        step_reg    <= '0;
                        state_reg   <= S_SQRT;
                    end
                end
                S_SQRT:
                begin
                    sq_src_reg  <= {sq_src_reg[47:0], 2'b00};
                    sq_rem_reg  <= sq_rem_new;
                    sq_root_reg <= sq_root_new;
                    step_reg    <= step_reg + 1'b1;
                    if (step_reg == 6'(SQ_STEPS - 1))
                    begin
                        inv_work_reg <= sq_root_new[24] ? INV_MAX : sq_root_new[23:0];
                        step_reg     <= '0;
                        state_reg    <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    row_stat_reg.mean    <= mean_full_reg[15:0];
                    row_stat_reg.inv_std <= inv_work_reg;
                    sum_acc_reg          <= '0;
                    sum_sq_acc_reg       <= '0;
                    stats_count_reg      <= '0;
                    state_reg            <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    `LNU_ASSERT_IMP(a_pop_only_idle, q_pop, state_reg == S_IDLE,
        "queue popped during row finish")
    `LNU_ASSERT_NEXT(a_done_clears, state_reg == S_DONE,
        stats_count_reg == '0 && state_reg == S_IDLE, "row finish did not clear count")
    `LNU_ASSERT_IMP(a_sqrt_bound, state_reg == S_SQRT,
        step_reg < 6'(SQ_STEPS), "root iteration overran")

endmodule

// ===== sv/lnu_norm.sv =====
// ----------------------------------------------------------------------------
// lnu_norm
// normalize datapath, four stages ending in the output register
// ----------------------------------------------------------------------------
module lnu_norm #(
    parameter int DATA_WIDTH = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                issue,
    input  lnu_pkg::in_item_t   item,
    input  lnu_pkg::row_stat_t  row_stat,
    output logic                ready,
    output logic                out_valid,
    input  logic                out_stall,
    output lnu_pkg::out_item_t  out_data
);
    import lnu_pkg::*;

    localparam logic signed [35:0] Y_HI = 36'((64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1);
    localparam logic signed [35:0] Y_LO = -Y_HI - 36'sd1;

    logic                 v1_reg, v2_reg, v3_reg, out_valid_reg;
    logic signed [16:0]   diff_reg;
    logic [INV_W-1:0]     inv_reg;
    logic signed [15:0]   g1_reg, g2_reg, b1_reg, b2_reg, b3_reg;
    logic signed [41:0]   t_reg, t_next;
    logic signed [37:0]   pl_reg, pl_next;
    logic signed [36:0]   ph_reg, ph_next;
    logic signed [16:0]   diff_next;
    logic signed [57:0]   p_sum;
    logic signed [35:0]   y_sum;
    out_item_t            out_reg, out_next;

    assign ready     = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        diff_next = {item.x_value[15], item.x_value} - {row_stat.mean[15], row_stat.mean};
        t_next    = diff_reg * $signed({1'b0, inv_reg});
        pl_next   = $signed({1'b0, t_reg[20:0]}) * g2_reg;
        ph_next   = $signed(t_reg[41:21]) * g2_reg;
        p_sum     = $signed({ph_reg, 21'd0}) + 58'(pl_reg) + 58'sd8388608;
        y_sum     = 36'($signed(p_sum[57:24])) + 36'(b3_reg);
        if (y_sum > Y_HI)
        begin
            out_next.y_value   = Y_HI[15:0];
            out_next.saturated = 1'b1;
        end
        else if (y_sum < Y_LO)
        begin
            out_next.y_value   = Y_LO[15:0];
            out_next.saturated = 1'b1;
        end
        else
        begin
            out_next.y_value   = y_sum[15:0];
            out_next.saturated = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready)
        begin
            diff_reg <= diff_next;
            inv_reg  <= row_stat.inv_std;
            g1_reg   <= item.gamma;
            b1_reg   <= item.beta;
            t_reg    <= t_next;
            g2_reg   <= g1_reg;
            b2_reg   <= b1_reg;
            pl_reg   <= pl_next;
            ph_reg   <= ph_next;
            b3_reg   <= b2_reg;
            out_reg  <= out_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (ready)
        begin
            v1_reg        <= issue;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            out_valid_reg <= v3_reg;
        end
    end

endmodule

// ===== sv/layer_normalization_unit.sv =====
// ----------------------------------------------------------------------------
// layer_normalization_unit
// two-pass fixed-point layer normalization of one row
// ----------------------------------------------------------------------------
// Statistics requests (command 0) are taken one per cycle while the back end
// is idle and add x and x*x into the row accumulators; normalize requests
// (command 1) also enter one per cycle while idle and the datapath is ready,
// and leave through a four-stage multiply datapath ending in the output
// register. When the statistics request that completes a row is taken, the
// back end runs the row finish on a shared one-bit-per-cycle divider and a
// two-bits-per-cycle root unit: three 49-step divides, a square, the
// variance, a 25-step root and the commit, with the third divide and the
// root skipped when variance plus epsilon is zero. Meanwhile the four-deep
// queue keeps taking requests and then raises in_stall. Normalize requests
// always use the last finished row; before any row finishes they return
// beta. Configuration writes are always ready and take effect at once.
// ----------------------------------------------------------------------------
module layer_normalization_unit #(
    parameter int MAX_ROW_LEN = 4096,
    parameter int DATA_WIDTH  = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // request channel
    input  logic                        in_valid,
    output logic                        in_stall,
    input  lnu_pkg::in_item_t           in_data,
    // result channel
    output logic                        out_valid,
    input  logic                        out_stall,
    output lnu_pkg::out_item_t          out_data,
    // configuration writes
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic                        cfg_index,
    input  logic [lnu_pkg::CFG_W-1:0]   cfg_data
);
    import lnu_pkg::*;

    logic [ROW_LEN_W-1:0]  row_len_reg;
    logic [EPS_W-1:0]      epsilon_reg;

    logic       q_valid, q_pop;
    in_item_t   q_item;
    logic       norm_ready, norm_issue;
    row_stat_t  row_stat;

    // registers are always writable
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_len_reg <= ROW_LEN_W'(1);
            epsilon_reg <= EPS_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_ROW_LEN: row_len_reg <= cfg_data[ROW_LEN_W-1:0];
                REG_EPSILON: epsilon_reg <= cfg_data[EPS_W-1:0];
                default:     ;
            endcase
        end
    end

    // front: intake queue
    lnu_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    // back: issue control, accumulation and row finish
    lnu_stats #(
        .MAX_ROW_LEN (MAX_ROW_LEN)
    ) u_stats (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop),
        .norm_ready (norm_ready),
        .norm_issue (norm_issue),
        .row_len    (row_len_reg),
        .epsilon    (epsilon_reg),
        .row_stat   (row_stat)
    );

    // back: normalize datapath and output register
    lnu_norm #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .issue     (norm_issue),
        .item      (q_item),
        .row_stat  (row_stat),
        .ready     (norm_ready),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

// ===== test/tb_layer_normalization_unit.sv =====
// ----------------------------------------------------------------------------
// tb_layer_normalization_unit
// self-checking regression for the layer normalization unit
// ----------------------------------------------------------------------------
// A queue of pending requests is filled phase by phase. A clocked driver
// offers them and a clocked monitor compares every result with the oldest
// prediction. The predictor keeps its own row accumulators and statistics.
// Configuration is written only when the unit is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_layer_normalization_unit;
    import lnu_pkg::*;

    localparam int MAX_ROW  = 4096;
    localparam int WD_LIMIT = 20000;
    localparam int SETTLE   = 200;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_stall;
    out_item_t out_data;
    logic      cfg_valid;
    logic      cfg_ready;
    logic      cfg_index;
    logic [CFG_W-1:0] cfg_data;

    layer_normalization_unit u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (out_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    // predictor state
    logic [12:0]        row_len_q;
    logic [15:0]        eps_q;
    longint             sum_q;
    longint             sumsq_q;
    int                 count_q;
    logic signed [15:0] mean_q;
    logic [23:0]        inv_q;

    in_item_t  pending_q[$];
    out_item_t expected_q[$];

    int send_idle_pct;
    int recv_stall_pct;
    int hold_cycles;
    int mismatches;
    int watchdog;
    bit timed_out;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic longint root_floor(longint v);
        longint r;
        longint b;
        r = 0;
        b = 64'sd1 <<< 60;
        while (b > v)
            b = b >>> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >>> 1) + b;
            end
            else
                r = r >>> 1;
            b = b >>> 2;
        end
        return r;
    endfunction

    // close the row: mean, variance, reciprocal deviation
    function automatic void close_row(int n);
        longint mean;
        longint esq;
        longint var_v;
        longint d;
        longint q;
        mean  = sum_q / n;
        esq   = sumsq_q / n;
        var_v = esq - mean * mean;
        if (var_v < 0)
            var_v = 0;
        d = var_v + eps_q;
        if (d == 0)
            q = 24'hFFFFFF;
        else
        begin
            q = root_floor((64'sd1 <<< 48) / d);
            if (q > 24'hFFFFFF)
                q = 24'hFFFFFF;
        end
        mean_q  = mean[15:0];
        inv_q   = q[23:0];
        sum_q   = 0;
        sumsq_q = 0;
        count_q = 0;
    endfunction

    function automatic void predict_norm(in_item_t it);
        int n;
        longint x;
        longint p;
        longint y;
        out_item_t r;
        x = it.x_value;
        if (it.command == CMD_STATS)
        begin
            n = int'(row_len_q);
            if (n == 0)
                n = 1;
            if (n > MAX_ROW)
                n = MAX_ROW;
            sum_q   = sum_q + x;
            sumsq_q = sumsq_q + x * x;
            count_q = count_q + 1;
            if (count_q >= n)
                close_row(n);
            return;
        end
        p = (x - mean_q) * longint'(inv_q) * longint'(it.gamma);
        // arithmetic shift is a floor shift
        y = ((p + (64'sd1 <<< 23)) >>> 24) + it.beta;
        r.saturated = 1'b0;
        if (y > 32767)
        begin
            y = 32767;
            r.saturated = 1'b1;
        end
        else if (y < -32768)
        begin
            y = -32768;
            r.saturated = 1'b1;
        end
        r.y_value = y[15:0];
        expected_q.push_back(r);
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
        end
        else if (!in_valid || !in_stall)
        begin
            if (in_valid)
                predict_norm(in_data);
            if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                in_data  <= pending_q.pop_front();
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // monitor and receiver stall
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result y=%0d sat=%0b",
                                 out_data.y_value, out_data.saturated);
                end
                else
                begin
                    out_item_t e;
                    e = expected_q.pop_front();
                    if (e.y_value !== out_data.y_value
                        || e.saturated !== out_data.saturated)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected y=%0d sat=%0b, got y=%0d sat=%0b",
                                     e.y_value, e.saturated,
                                     out_data.y_value, out_data.saturated);
                    end
                end
            end
            if (hold_cycles > 0)
            begin
                hold_cycles <= hold_cycles - 1;
                out_stall   <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // watchdog on cycles without any accepted request or result
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            watchdog <= 0;
        else
            watchdog <= watchdog + 1;
        if (watchdog > WD_LIMIT && !timed_out)
        begin
            timed_out = 1'b1;
            $display("layer_normalization_unit regression: fail");
            $finish;
        end
    end

    function automatic in_item_t make_item(logic cmd);
        in_item_t it;
        it.command = cmd;
        it.x_value = 16'($urandom);
        it.gamma   = 16'($urandom);
        it.beta    = 16'($urandom);
        // keep most values moderate so results do not all saturate
        if ($urandom_range(3) != 0)
        begin
            it.x_value = $signed(it.x_value) >>> $urandom_range(8);
            it.gamma   = $signed(it.gamma) >>> $urandom_range(10);
            it.beta    = $signed(it.beta) >>> $urandom_range(8);
        end
        return it;
    endfunction

    task automatic push_item(logic cmd, int x, int g, int b);
        in_item_t it;
        it.command = cmd;
        it.x_value = 16'(x);
        it.gamma   = 16'(g);
        it.beta    = 16'(b);
        pending_q.push_back(it);
    endtask

    // wait until all requests are taken and every result has come back
    task automatic drain();
        while (pending_q.size() != 0 || in_valid || expected_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [CFG_W-1:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == REG_ROW_LEN)
            row_len_q = val[12:0];
        else
            eps_q = val;
    endtask

    // one row of statistics followed by its normalize pass
    task automatic push_row(int len);
        for (int i = 0; i < len; i++)
            pending_q.push_back(make_item(CMD_STATS));
        for (int i = 0; i < len; i++)
            pending_q.push_back(make_item(CMD_NORM));
    endtask

    task automatic run_phase(int len, int eps, int n_items, int idle, int stall);
        int sent;
        drain();
        write_reg(REG_ROW_LEN, CFG_W'(len));
        write_reg(REG_EPSILON, CFG_W'(eps));
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        sent = 0;
        while (sent < n_items)
        begin
            int l;
            l = (len < 1) ? 1 : (len > 16 ? 16 : len);
            if ($urandom_range(9) == 0)
            begin
                pending_q.push_back(make_item(1'($urandom_range(1))));
                sent++;
            end
            else
            begin
                if (len > 16)
                    l = 0;
                if (l == 0)
                begin
                    pending_q.push_back(make_item($urandom_range(3) != 0));
                    sent++;
                end
                else
                begin
                    push_row(l);
                    sent += 2 * l;
                end
            end
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_ROW_LEN;
        cfg_data  = '0;
        row_len_q = 13'd1;
        eps_q     = 16'd1;
        sum_q = 0; sumsq_q = 0; count_q = 0;
        mean_q = '0; inv_q = '0;
        send_idle_pct = 0; recv_stall_pct = 0; hold_cycles = 0;
        mismatches = 0; watchdog = 0; timed_out = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: normalize before any finished row gives beta
        push_item(CMD_NORM, 16'h0100, 16'h7FFF, 16'h8000);
        push_item(CMD_NORM, 16'h8000, 16'h8000, 16'h7FFF);
        drain();
        // zero variance with zero epsilon: capped reciprocal, saturating
        write_reg(REG_EPSILON, 16'd0);
        write_reg(REG_ROW_LEN, 16'd2);
        push_item(CMD_STATS, 16'h0200, 0, 0);
        push_item(CMD_STATS, 16'h0200, 0, 0);
        push_item(CMD_NORM, 16'h0300, 16'h0100, 0);
        push_item(CMD_NORM, 16'h0200, 16'h7FFF, 16'h7FFF);
        push_item(CMD_NORM, 16'h0100, 16'h7FFF, 16'h8000);
        // extremes of x, with normalize interleaved in an open row
        push_item(CMD_STATS, 16'h7FFF, 0, 0);
        push_item(CMD_NORM, 16'h0000, 16'h0100, 16'h0001);
        push_item(CMD_STATS, 16'h8000, 0, 0);
        push_item(CMD_NORM, 16'h7FFF, 16'h7FFF, 16'h0000);
        push_item(CMD_NORM, 16'h8000, 16'h8000, 16'hFFFF);
        drain();
        // row length zero acts as one, beyond maximum acts as maximum
        write_reg(REG_ROW_LEN, 16'd0);
        write_reg(REG_EPSILON, 16'hFFFF);
        push_item(CMD_STATS, 16'h1234, 0, 0);
        push_item(CMD_NORM, 16'h1000, 16'h0100, 16'h0010);
        drain();
        write_reg(REG_ROW_LEN, 16'hFFFF);
        for (int i = 0; i < 6; i++)
            push_item(CMD_STATS, $urandom, 0, 0);
        push_item(CMD_NORM, 16'h0100, 16'h0100, 0);
        drain();
        // maximum row length and full-width request values
        write_reg(REG_ROW_LEN, CFG_W'(MAX_ROW));
        for (int i = 0; i < 4; i++)
            push_item(CMD_NORM, $urandom, $urandom, $urandom);

        // random phases
        run_phase(4, 1, 200, 0, 0);
        run_phase(1, 0, 150, 53, 0);
        run_phase(7, 65535, 150, 0, 53);
        run_phase(3, 256, 150, 19, 19);
        // long receiver hold-off while the sender keeps offering
        drain();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_cycles    = 400;
        run_phase(2, 16, 150, 0, 0);
        run_phase(16, 4, 150, 19, 53);
        // a row of maximum length stays open, with normalize overlapping it
        run_phase(MAX_ROW, 100, 150, 0, 0);
        drain();

        if (mismatches == 0 && !timed_out)
            $display("layer_normalization_unit regression: pass");
        else
            $display("layer_normalization_unit regression: fail");
        $finish;
    end

endmodule
